// File: hdl/tlpc_pkg.sv
// Shared types, phase codes, register indexes and phase entry function for the light sequencer.
package tlpc_pkg;

	localparam logic [2:0] PH_GREEN  = 3'd0;
	localparam logic [2:0] PH_YELLOW = 3'd1;
	localparam logic [2:0] PH_FLASH  = 3'd2;
	localparam logic [2:0] PH_ALLRED = 3'd3;
	localparam logic [2:0] PH_SOLID  = 3'd4;
	localparam logic [2:0] PH_BLINK  = 3'd5;
	localparam logic [2:0] PH_CLEAR  = 3'd6;

	localparam logic [2:0] REG_GREEN     = 3'd0;
	localparam logic [2:0] REG_YELLOW    = 3'd1;
	localparam logic [2:0] REG_FLASH     = 3'd2;
	localparam logic [2:0] REG_ALLRED    = 3'd3;
	localparam logic [2:0] REG_SOLID     = 3'd4;
	localparam logic [2:0] REG_BLINK     = 3'd5;
	localparam logic [2:0] REG_CLEARANCE = 3'd6;

	localparam logic [7:0] RST_GREEN     = 8'd10;
	localparam logic [7:0] RST_YELLOW    = 8'd5;
	localparam logic [7:0] RST_FLASH     = 8'd10;
	localparam logic [7:0] RST_ALLRED    = 8'd5;
	localparam logic [7:0] RST_SOLID     = 8'd5;
	localparam logic [7:0] RST_BLINK     = 8'd10;
	localparam logic [7:0] RST_CLEARANCE = 8'd2;

	typedef struct packed {
		logic tick;
		logic button;
	} item_t;

	typedef struct packed {
		logic ew_green;
		logic ew_yellow;
		logic ew_red;
		logic ns_green;
		logic ns_yellow;
		logic ns_red;
		logic walk_lamp;
		logic stop_lamp;
		logic buzzer_on;
	} result_t;

	typedef struct packed {
		logic [7:0] green_time;
		logic [7:0] yellow_time;
		logic [7:0] flash_time;
		logic [7:0] all_red_time;
		logic [7:0] walk_solid_time;
		logic [7:0] walk_blink_time;
		logic [7:0] clearance_time;
	} cfg_t;

	typedef struct packed {
		logic [2:0] phase;
		logic [7:0] countdown;
		logic       axis_is_ns;
		logic       blink_bit;
	} seq_t;

	function automatic seq_t enter_phase(seq_t s, logic [2:0] ph, cfg_t cfg);
		seq_t r;
		r = s;
		r.phase = ph;
		r.blink_bit = 1'b0;
		unique case (ph)
			PH_GREEN:  r.countdown = cfg.green_time;
			PH_YELLOW: r.countdown = cfg.yellow_time;
			PH_FLASH: begin
				r.countdown = cfg.flash_time;
				r.blink_bit = 1'b1;
			end
			PH_ALLRED: r.countdown = cfg.all_red_time;
			PH_SOLID: begin
				r.countdown = cfg.walk_solid_time;
				r.blink_bit = 1'b1;
			end
			PH_BLINK:  r.countdown = cfg.walk_blink_time;
			default: begin
				if (cfg.clearance_time == 8'd0) begin
					r.phase = PH_GREEN;
					r.countdown = cfg.green_time;
				end else begin
					r.phase = PH_CLEAR;
					r.countdown = cfg.clearance_time;
				end
			end
		endcase
		return r;
	endfunction

endpackage

// File: hdl/tlpc_step.sv
// Next sequencer state and lamp outputs for one input beat.
module tlpc_step (
	input  tlpc_pkg::seq_t    cur,
	input  tlpc_pkg::cfg_t    cfg,
	input  tlpc_pkg::item_t   item,
	output tlpc_pkg::seq_t    nxt,
	output tlpc_pkg::result_t result
);

	tlpc_pkg::seq_t pre;
	logic ag, ay, ar, walk, stop, buzz;

	always_comb begin
		pre = cur;
		if (item.button && (cur.phase == tlpc_pkg::PH_GREEN ||
			cur.phase == tlpc_pkg::PH_YELLOW)) begin
			pre = tlpc_pkg::enter_phase(cur, tlpc_pkg::PH_FLASH, cfg);
		end
	end

	always_comb begin
		nxt = pre;
		if (item.tick) begin
			priority if (pre.phase > tlpc_pkg::PH_CLEAR) begin
				nxt = tlpc_pkg::enter_phase(pre, tlpc_pkg::PH_GREEN, cfg);
			end else if (pre.countdown <= 8'd1) begin
				unique case (pre.phase)
					tlpc_pkg::PH_GREEN:
						nxt = tlpc_pkg::enter_phase(pre, tlpc_pkg::PH_YELLOW, cfg);
					tlpc_pkg::PH_YELLOW: begin
						nxt = tlpc_pkg::enter_phase(pre, tlpc_pkg::PH_GREEN, cfg);
						nxt.axis_is_ns = ~pre.axis_is_ns;
					end
					tlpc_pkg::PH_FLASH:
						nxt = tlpc_pkg::enter_phase(pre, tlpc_pkg::PH_ALLRED, cfg);
					tlpc_pkg::PH_ALLRED:
						nxt = tlpc_pkg::enter_phase(pre, tlpc_pkg::PH_SOLID, cfg);
					tlpc_pkg::PH_SOLID:
						nxt = tlpc_pkg::enter_phase(pre, tlpc_pkg::PH_BLINK, cfg);
					tlpc_pkg::PH_BLINK:
						nxt = tlpc_pkg::enter_phase(pre, tlpc_pkg::PH_CLEAR, cfg);
					default:
						nxt = tlpc_pkg::enter_phase(pre, tlpc_pkg::PH_GREEN, cfg);
				endcase
			end else begin
				nxt.countdown = pre.countdown - 8'd1;
				if (pre.phase == tlpc_pkg::PH_FLASH || pre.phase == tlpc_pkg::PH_BLINK) begin
					nxt.blink_bit = ~pre.blink_bit;
				end else begin
					nxt.blink_bit = 1'b0;
				end
			end
		end
	end

	always_comb begin
		ag = 1'b0;
		ay = 1'b0;
		ar = 1'b1;
		walk = 1'b0;
		stop = 1'b1;
		buzz = 1'b0;
		unique case (nxt.phase)
			tlpc_pkg::PH_GREEN: begin
				ag = 1'b1;
				ar = 1'b0;
			end
			tlpc_pkg::PH_YELLOW: begin
				ay = 1'b1;
				ar = 1'b0;
			end
			tlpc_pkg::PH_FLASH: begin
				ay = nxt.blink_bit;
				ar = 1'b0;
			end
			tlpc_pkg::PH_SOLID: begin
				walk = 1'b1;
				stop = 1'b0;
				buzz = nxt.blink_bit;
			end
			tlpc_pkg::PH_BLINK: begin
				walk = nxt.blink_bit;
				stop = 1'b0;
				buzz = nxt.blink_bit;
			end
			default: begin
				ar = 1'b1;
			end
		endcase
	end

	always_comb begin
		result.ew_green  = nxt.axis_is_ns ? 1'b0 : ag;
		result.ew_yellow = nxt.axis_is_ns ? 1'b0 : ay;
		result.ew_red    = nxt.axis_is_ns ? 1'b1 : ar;
		result.ns_green  = nxt.axis_is_ns ? ag : 1'b0;
		result.ns_yellow = nxt.axis_is_ns ? ay : 1'b0;
		result.ns_red    = nxt.axis_is_ns ? ar : 1'b1;
		result.walk_lamp = walk;
		result.stop_lamp = stop;
		result.buzzer_on = buzz;
	end

endmodule

// File: hdl/traffic_light_pedestrian_controller_core.sv
// Top level of the two-axis traffic light sequencer with pedestrian request.
// Each input beat (tick, button) yields one result beat with the lamp states after
// that beat is applied. A beat is registered on entry, the sequencer state and lamps
// are updated by one short step of logic, and the result lands in an output register;
// a new beat is taken every cycle while the result side keeps up. The seven timing
// registers are written through the configuration channel (index 0 green_time to
// 6 clearance_time; higher indexes are dropped) and apply when a phase is next
// entered. Button beats outside the car cycle are ignored.
module traffic_light_pedestrian_controller_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  tlpc_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_ready,
	output tlpc_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	tlpc_pkg::cfg_t    cfg_q;
	tlpc_pkg::seq_t    seq_q;
	tlpc_pkg::seq_t    seq_nxt;
	tlpc_pkg::item_t   item_s1;
	logic              valid_s1;
	tlpc_pkg::result_t step_result;
	tlpc_pkg::result_t result_q;
	logic              result_valid_q;
	logic              advance;

	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.green_time      <= tlpc_pkg::RST_GREEN;
			cfg_q.yellow_time     <= tlpc_pkg::RST_YELLOW;
			cfg_q.flash_time      <= tlpc_pkg::RST_FLASH;
			cfg_q.all_red_time    <= tlpc_pkg::RST_ALLRED;
			cfg_q.walk_solid_time <= tlpc_pkg::RST_SOLID;
			cfg_q.walk_blink_time <= tlpc_pkg::RST_BLINK;
			cfg_q.clearance_time  <= tlpc_pkg::RST_CLEARANCE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tlpc_pkg::REG_GREEN:     cfg_q.green_time      <= cfg_data;
				tlpc_pkg::REG_YELLOW:    cfg_q.yellow_time     <= cfg_data;
				tlpc_pkg::REG_FLASH:     cfg_q.flash_time      <= cfg_data;
				tlpc_pkg::REG_ALLRED:    cfg_q.all_red_time    <= cfg_data;
				tlpc_pkg::REG_SOLID:     cfg_q.walk_solid_time <= cfg_data;
				tlpc_pkg::REG_BLINK:     cfg_q.walk_blink_time <= cfg_data;
				tlpc_pkg::REG_CLEARANCE: cfg_q.clearance_time  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	tlpc_step u_step (
		.cur    (seq_q),
		.cfg    (cfg_q),
		.item   (item_s1),
		.nxt    (seq_nxt),
		.result (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q.phase      <= tlpc_pkg::PH_GREEN;
			seq_q.countdown  <= tlpc_pkg::RST_GREEN;
			seq_q.axis_is_ns <= 1'b0;
			seq_q.blink_bit  <= 1'b0;
		end else if (advance) begin
			seq_q <= seq_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= step_result;
		end
	end

endmodule

// File: dv/traffic_light_pedestrian_controller_core_test.sv
// Self-checking testbench for the traffic light sequencer with pedestrian request.
module traffic_light_pedestrian_controller_core_test;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 60;
	localparam logic [7:0] POWER_ON [7] = '{tlpc_pkg::RST_GREEN, tlpc_pkg::RST_YELLOW,
		tlpc_pkg::RST_FLASH, tlpc_pkg::RST_ALLRED, tlpc_pkg::RST_SOLID,
		tlpc_pkg::RST_BLINK, tlpc_pkg::RST_CLEARANCE};

	typedef enum {TM_MIN, TM_SMALL, TM_ZERO, TM_MAX, TM_MIXED, TM_RESET} timing_mode_e;

	typedef struct {
		tlpc_pkg::item_t beat;
		int unsigned     gap;
	} offer_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	tlpc_pkg::item_t   item = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	tlpc_pkg::result_t result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [2:0]        cfg_index = '0;
	logic [7:0]        cfg_data = '0;

	logic              item_taken = 1'b0;
	logic              result_taken = 1'b0;
	offer_t            pending_beats [$];
	tlpc_pkg::result_t lamp_expect [$];
	int                gap_left = -1;
	int                hold_req = 0;
	int                hold_seen = 0;
	int                hold_left = 0;
	int                stall_left = 0;
	logic              rx_quiet = 1'b0;
	int                mismatch_count = 0;
	int                cycle_count = 0;

	logic [7:0]        timing [7];
	logic [2:0]        cur_phase;
	logic [7:0]        cur_count;
	logic              cur_ns;
	logic              cur_blink;

	traffic_light_pedestrian_controller_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void load_phase(input logic [2:0] ph);
		cur_phase = ph;
		cur_blink = 1'b0;
		unique case (ph)
			tlpc_pkg::PH_GREEN:  cur_count = timing[tlpc_pkg::REG_GREEN];
			tlpc_pkg::PH_YELLOW: cur_count = timing[tlpc_pkg::REG_YELLOW];
			tlpc_pkg::PH_FLASH: begin
				cur_count = timing[tlpc_pkg::REG_FLASH];
				cur_blink = 1'b1;
			end
			tlpc_pkg::PH_ALLRED: cur_count = timing[tlpc_pkg::REG_ALLRED];
			tlpc_pkg::PH_SOLID: begin
				cur_count = timing[tlpc_pkg::REG_SOLID];
				cur_blink = 1'b1;
			end
			tlpc_pkg::PH_BLINK:  cur_count = timing[tlpc_pkg::REG_BLINK];
			default: begin
				if (timing[tlpc_pkg::REG_CLEARANCE] == 8'd0) begin
					cur_phase = tlpc_pkg::PH_GREEN;
					cur_count = timing[tlpc_pkg::REG_GREEN];
				end else begin
					cur_phase = tlpc_pkg::PH_CLEAR;
					cur_count = timing[tlpc_pkg::REG_CLEARANCE];
				end
			end
		endcase
	endfunction

	function automatic void advance_second();
		if (cur_phase > tlpc_pkg::PH_CLEAR) begin
			load_phase(tlpc_pkg::PH_GREEN);
		end else if (cur_count <= 8'd1) begin
			unique case (cur_phase)
				tlpc_pkg::PH_GREEN:  load_phase(tlpc_pkg::PH_YELLOW);
				tlpc_pkg::PH_YELLOW: begin
					cur_ns = ~cur_ns;
					load_phase(tlpc_pkg::PH_GREEN);
				end
				tlpc_pkg::PH_FLASH:  load_phase(tlpc_pkg::PH_ALLRED);
				tlpc_pkg::PH_ALLRED: load_phase(tlpc_pkg::PH_SOLID);
				tlpc_pkg::PH_SOLID:  load_phase(tlpc_pkg::PH_BLINK);
				tlpc_pkg::PH_BLINK:  load_phase(tlpc_pkg::PH_CLEAR);
				default:             load_phase(tlpc_pkg::PH_GREEN);
			endcase
		end else begin
			cur_count = cur_count - 8'd1;
			if (cur_phase == tlpc_pkg::PH_FLASH || cur_phase == tlpc_pkg::PH_BLINK) begin
				cur_blink = ~cur_blink;
			end else begin
				cur_blink = 1'b0;
			end
		end
	endfunction

	function automatic tlpc_pkg::result_t lamps_after(input tlpc_pkg::item_t beat);
		tlpc_pkg::result_t r;
		logic              go;
		logic              amber;
		logic              halt;
		if (beat.button && (cur_phase == tlpc_pkg::PH_GREEN ||
			cur_phase == tlpc_pkg::PH_YELLOW)) begin
			load_phase(tlpc_pkg::PH_FLASH);
		end
		if (beat.tick) begin
			advance_second();
		end
		r = '0;
		r.stop_lamp = 1'b1;
		go = 1'b0;
		amber = 1'b0;
		halt = 1'b1;
		unique case (cur_phase)
			tlpc_pkg::PH_GREEN: begin
				go = 1'b1;
				halt = 1'b0;
			end
			tlpc_pkg::PH_YELLOW: begin
				amber = 1'b1;
				halt = 1'b0;
			end
			tlpc_pkg::PH_FLASH: begin
				amber = cur_blink;
				halt = 1'b0;
			end
			tlpc_pkg::PH_SOLID: begin
				r.walk_lamp = 1'b1;
				r.stop_lamp = 1'b0;
				r.buzzer_on = cur_blink;
			end
			tlpc_pkg::PH_BLINK: begin
				r.walk_lamp = cur_blink;
				r.stop_lamp = 1'b0;
				r.buzzer_on = cur_blink;
			end
			default: ;
		endcase
		if (cur_ns) begin
			r.ew_red = 1'b1;
			r.ns_green = go;
			r.ns_yellow = amber;
			r.ns_red = halt;
		end else begin
			r.ns_red = 1'b1;
			r.ew_green = go;
			r.ew_yellow = amber;
			r.ew_red = halt;
		end
		return r;
	endfunction

	function automatic logic [7:0] pick_time(input timing_mode_e m, input int r);
		unique case (m)
			TM_MIN:   return (r == tlpc_pkg::REG_CLEARANCE) ? 8'd0 : 8'd1;
			TM_SMALL: return (r == tlpc_pkg::REG_CLEARANCE) ? 8'($urandom_range(0, 3))
				: 8'($urandom_range(1, 4));
			TM_ZERO:  return 8'd0;
			TM_MAX:   return 8'hFF;
			TM_MIXED: return ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 6));
			default:  return POWER_ON[r];
		endcase
	endfunction

	// drive item beats
	always @(negedge clk) begin
		offer_t next_offer;
		if (arst_n && (!item_valid || item_taken)) begin
			if (gap_left < 0 && pending_beats.size() != 0) begin
				gap_left = pending_beats[0].gap;
			end
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (gap_left == 0) begin
				next_offer = pending_beats.pop_front();
				item <= next_offer.beat;
				item_valid <= 1'b1;
				gap_left = -1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// drive result ready: per-beat stalls plus requested long hold-offs
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (result_taken) begin
			stall_left = rx_quiet ? 0 : $urandom_range(0, 9);
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// sample handshakes, predict and check
	always @(posedge clk) begin
		tlpc_pkg::result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			item_taken <= item_valid && item_ready;
			result_taken <= result_valid && result_ready;
			if (arst_n) begin
				if (cfg_valid && cfg_ready && cfg_index <= tlpc_pkg::REG_CLEARANCE) begin
					timing[cfg_index] = cfg_data;
				end
				if (result_valid && result_ready) begin
					if (lamp_expect.size() == 0) begin
						mismatch_count++;
						$display("%0t: unexpected result beat, expected none, got %p",
							$time, result);
					end else begin
						want = lamp_expect.pop_front();
						if (result !== want) begin
							mismatch_count++;
							$display("%0t: lamp mismatch, expected %p, got %p",
								$time, want, result);
						end
					end
				end
				if (item_valid && item_ready) begin
					lamp_expect.push_back(lamps_after(item));
				end
			end
		end
	end

	task automatic queue_beat(input logic tick, input logic button, input logic quiet);
		offer_t o;
		o.beat.tick = tick;
		o.beat.button = button;
		o.gap = quiet ? 0 : $urandom_range(0, 9);
		pending_beats.push_back(o);
	endtask

	task automatic wait_all_done();
		do begin
			@(posedge clk);
		end while (pending_beats.size() != 0 || item_valid || lamp_expect.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(posedge clk);
		end while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		timing_mode_e plan [8];
		logic         tx_quiet;
		plan = '{TM_MIN, TM_SMALL, TM_ZERO, TM_SMALL, TM_MAX, TM_MIXED, TM_RESET, TM_SMALL};
		for (int r = tlpc_pkg::REG_GREEN; r <= tlpc_pkg::REG_CLEARANCE; r++) begin
			timing[r] = POWER_ON[r];
		end
		cur_ns = 1'b0;
		load_phase(tlpc_pkg::PH_GREEN);
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// reset timing: idle, tick, button with tick, button in flash, tick, button with tick
		queue_beat(1'b0, 1'b0, 1'b0);
		queue_beat(1'b1, 1'b0, 1'b0);
		queue_beat(1'b1, 1'b1, 1'b0);
		queue_beat(1'b0, 1'b1, 1'b0);
		queue_beat(1'b1, 1'b0, 1'b0);
		queue_beat(1'b1, 1'b1, 1'b0);
		wait_all_done();

		// shortest phases, clearance skipped, out-of-range index dropped
		for (int r = tlpc_pkg::REG_GREEN; r <= tlpc_pkg::REG_CLEARANCE; r++) begin
			write_reg(r[2:0], pick_time(TM_MIN, r));
		end
		write_reg(tlpc_pkg::REG_CLEARANCE + 3'd1, 8'hA5);
		queue_beat(1'b1, 1'b0, 1'b0);
		queue_beat(1'b1, 1'b0, 1'b0);
		queue_beat(1'b0, 1'b1, 1'b0);
		queue_beat(1'b1, 1'b0, 1'b0);
		queue_beat(1'b0, 1'b1, 1'b0);
		queue_beat(1'b1, 1'b0, 1'b0);
		queue_beat(1'b1, 1'b1, 1'b0);
		queue_beat(1'b1, 1'b0, 1'b0);
		queue_beat(1'b1, 1'b0, 1'b0);
		queue_beat(1'b1, 1'b1, 1'b0);
		queue_beat(1'b1, 1'b0, 1'b0);
		queue_beat(1'b1, 1'b0, 1'b0);
		queue_beat(1'b1, 1'b0, 1'b0);
		wait_all_done();

		for (int p = 0; p < 8; p++) begin
			for (int r = tlpc_pkg::REG_GREEN; r <= tlpc_pkg::REG_CLEARANCE; r++) begin
				write_reg(r[2:0], pick_time(plan[p], r));
			end
			if ($urandom_range(0, 1) == 0) begin
				write_reg(tlpc_pkg::REG_CLEARANCE + 3'd1, 8'($urandom));
			end
			tx_quiet = (p == 1 || p == 3);
			rx_quiet = (p == 1);
			if (p == 3) begin
				hold_req++;
			end
			for (int n = 0; n < 225; n++) begin
				queue_beat($urandom_range(0, 99) < 75, $urandom_range(0, 99) < 12, tx_quiet);
			end
			wait_all_done();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/tlpc_pkg.sv
hdl/tlpc_step.sv
hdl/traffic_light_pedestrian_controller_core.sv
dv/traffic_light_pedestrian_controller_core_test.sv
